// ===== rtl/dmsf_pkg.sv =====
// Package for the drive mode safety state machine.
// Holds the item structs, state, event and response codes, the configuration
// struct and the state transition function. No dependencies.
`timescale 1ns / 1ps

package dmsf_pkg;

    // throttle path width and reverse scale format
    localparam int THROTTLE_W = 12;
    localparam int SCALE_W    = 9;
    localparam int SCALE_FRAC = 8;
    localparam int PROD_W     = THROTTLE_W + SCALE_W;
    localparam logic [THROTTLE_W-1:0] THR_MAX = {THROTTLE_W{1'b1}};

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SCALE_W;

    // length of the ready-to-drive beep that the beep request asks for
    localparam int BEEP_MS = 1000;

    typedef enum logic [2:0] {
        MODE_INIT    = 3'd0,
        MODE_IDLE    = 3'd1,
        MODE_NEUTRAL = 3'd2,
        MODE_FWD     = 3'd3,
        MODE_REV     = 3'd4,
        MODE_LATCHED = 3'd5
    } drive_state_t;

    typedef enum logic [2:0] {
        EV_OK       = 3'd0,
        EV_READY    = 3'd1,
        EV_NOTREADY = 3'd2,
        EV_RTD      = 3'd3,
        EV_RTDREV   = 3'd4,
        EV_STOP     = 3'd5,
        EV_FAULT    = 3'd6
    } drive_ev_t;

    typedef enum logic [1:0] {
        RSP_CUT     = 2'd0,
        RSP_NEUTRAL = 2'd1,
        RSP_SDC     = 2'd2,
        RSP_LATCH   = 2'd3
    } fault_rsp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_APPS_RSP    = 3'd0,
        REG_PLAUS_RSP   = 3'd1,
        REG_RANGE_RSP   = 3'd2,
        REG_TIMEOUT_RSP = 3'd3,
        REG_TS_LOST_RSP = 3'd4,
        REG_REV_ENABLE  = 3'd5,
        REG_REV_SCALE   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        fault_rsp_t           apps_disagree_response;
        fault_rsp_t           pedal_plaus_response;
        fault_rsp_t           sensor_range_response;
        fault_rsp_t           can_timeout_response;
        fault_rsp_t           ts_lost_response;
        logic                 reverse_enable;
        logic [SCALE_W-1:0]   reverse_scale;
    } cfg_t;

    typedef struct packed {
        logic                  brake_pedal;
        logic                  forward_switch;
        logic                  reverse_switch;
        logic                  ready_button;
        logic                  tractive_active;
        logic                  fault_apps;
        logic                  fault_plausibility;
        logic                  fault_range;
        logic                  fault_timeout;
        logic [THROTTLE_W-1:0] throttle_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0]            drive_state_out;
        logic                  throttle_enable;
        logic [THROTTLE_W-1:0] throttle_out;
        logic                  inverter_relay;
        logic                  stop_lamp;
        logic                  shutdown_open;
        logic                  beep_request;
        logic                  motor_reverse;
    } out_item_t;

    // state transition for one tick, given the event raised in that tick
    function automatic drive_state_t next_state(drive_state_t cur, drive_ev_t ev);
        drive_state_t nxt;
        nxt = MODE_LATCHED;
        if (ev != EV_FAULT) begin
            case (cur)
                MODE_INIT:  nxt = MODE_IDLE;
                MODE_IDLE:  nxt = (ev == EV_READY) ? MODE_NEUTRAL : MODE_IDLE;
                MODE_NEUTRAL:
                begin
                    case (ev)
                        EV_NOTREADY, EV_STOP: nxt = MODE_IDLE;
                        EV_RTD:               nxt = MODE_FWD;
                        EV_RTDREV:            nxt = MODE_REV;
                        default:              nxt = MODE_NEUTRAL;
                    endcase
                end
                MODE_FWD:
                begin
                    case (ev)
                        EV_NOTREADY: nxt = MODE_IDLE;
                        EV_STOP:     nxt = MODE_NEUTRAL;
                        default:     nxt = MODE_FWD;
                    endcase
                end
                MODE_REV:
                begin
                    case (ev)
                        EV_NOTREADY: nxt = MODE_IDLE;
                        EV_STOP:     nxt = MODE_NEUTRAL;
                        default:     nxt = MODE_REV;
                    endcase
                end
                default:    nxt = MODE_LATCHED;
            endcase
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/dmsf_cfg.sv =====
// Configuration register file for the drive mode safety state machine.
// Plain indexed write port, no read-back. Depends on dmsf_pkg.
`timescale 1ns / 1ps

module dmsf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dmsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmsf_pkg::CFG_DATA_W-1:0] cfg_data,
    output dmsf_pkg::cfg_t                 cfg
);
    import dmsf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode one register write; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_APPS_RSP:    cfg_next.apps_disagree_response = fault_rsp_t'(cfg_data[1:0]);
                REG_PLAUS_RSP:   cfg_next.pedal_plaus_response   = fault_rsp_t'(cfg_data[1:0]);
                REG_RANGE_RSP:   cfg_next.sensor_range_response  = fault_rsp_t'(cfg_data[1:0]);
                REG_TIMEOUT_RSP: cfg_next.can_timeout_response   = fault_rsp_t'(cfg_data[1:0]);
                REG_TS_LOST_RSP: cfg_next.ts_lost_response       = fault_rsp_t'(cfg_data[1:0]);
                REG_REV_ENABLE:  cfg_next.reverse_enable         = cfg_data[0];
                REG_REV_SCALE:   cfg_next.reverse_scale          = cfg_data[SCALE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank with documented reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.apps_disagree_response <= RSP_CUT;
            cfg_reg.pedal_plaus_response   <= RSP_NEUTRAL;
            cfg_reg.sensor_range_response  <= RSP_NEUTRAL;
            cfg_reg.can_timeout_response   <= RSP_NEUTRAL;
            cfg_reg.ts_lost_response       <= RSP_NEUTRAL;
            cfg_reg.reverse_enable         <= 1'b0;
            cfg_reg.reverse_scale          <= SCALE_W'(128);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dmsf_core.sv =====
// Combinational tick logic of the drive mode safety state machine: event
// decode, fault response, reverse throttle scaling and next state.
// Depends on dmsf_pkg.
`timescale 1ns / 1ps

module dmsf_core (
    input  dmsf_pkg::drive_state_t cur_state,
    input  dmsf_pkg::in_item_t     item,
    input  dmsf_pkg::cfg_t         cfg,
    output dmsf_pkg::drive_state_t nxt_state,
    output dmsf_pkg::out_item_t    result
);
    import dmsf_pkg::*;

    logic [PROD_W-1:0]     rev_prod;
    logic [THROTTLE_W:0]   rev_shift;
    logic [THROTTLE_W-1:0] rev_thr;
    fault_rsp_t            rsp;
    logic                  fault_hit;

    // reverse throttle in units of 1/256, truncated then saturated
    assign rev_prod  = PROD_W'(item.throttle_in) * PROD_W'(cfg.reverse_scale);
    assign rev_shift = rev_prod[SCALE_FRAC +: THROTTLE_W+1];
    assign rev_thr   = rev_shift[THROTTLE_W] ? THR_MAX : rev_shift[THROTTLE_W-1:0];

    // first active fault picks the response; tractive loss wins
    always_comb
    begin
        fault_hit = 1'b1;
        rsp       = RSP_CUT;
        if (!item.tractive_active)
            rsp = cfg.ts_lost_response;
        else if (item.fault_apps)
            rsp = cfg.apps_disagree_response;
        else if (item.fault_plausibility)
            rsp = cfg.pedal_plaus_response;
        else if (item.fault_range)
            rsp = cfg.sensor_range_response;
        else if (item.fault_timeout)
            rsp = cfg.can_timeout_response;
        else
            fault_hit = 1'b0;
    end

    // per-state outputs and event
    always_comb
    begin
        drive_ev_t ev;
        logic      drv_fault;
        ev        = EV_OK;
        drv_fault = 1'b0;
        result                 = '0;
        result.shutdown_open   = 1'b1;

        case (cur_state)
            MODE_INIT:
            begin
                ev = EV_OK;
            end
            MODE_IDLE:
            begin
                result.stop_lamp     = item.brake_pedal;
                result.shutdown_open = 1'b0;
                if (item.forward_switch && item.tractive_active)
                    ev = EV_READY;
            end
            MODE_NEUTRAL:
            begin
                result.inverter_relay = 1'b1;
                result.stop_lamp      = item.brake_pedal;
                result.shutdown_open  = 1'b0;
                if (cfg.reverse_enable)
                begin
                    if (!(item.forward_switch || item.reverse_switch))
                        ev = EV_NOTREADY;
                    else if (item.reverse_switch && item.ready_button && item.brake_pedal)
                    begin
                        result.beep_request  = 1'b1;
                        result.motor_reverse = 1'b1;
                        ev = EV_RTDREV;
                    end
                    else if (item.forward_switch && item.ready_button && item.brake_pedal)
                    begin
                        result.beep_request = 1'b1;
                        ev = EV_RTD;
                    end
                end
                else if (!item.forward_switch)
                    ev = EV_NOTREADY;
                else if (item.ready_button && item.brake_pedal)
                begin
                    result.beep_request = 1'b1;
                    ev = EV_RTD;
                end
            end
            MODE_FWD, MODE_REV:
            begin
                result.inverter_relay = 1'b1;
                result.stop_lamp      = item.brake_pedal;
                result.shutdown_open  = 1'b0;
                result.motor_reverse  = (cur_state == MODE_REV);
                if ((cur_state == MODE_FWD) ? !item.forward_switch : !item.reverse_switch)
                    ev = EV_STOP;
                else if (fault_hit)
                    drv_fault = 1'b1;
                else
                begin
                    result.throttle_enable = 1'b1;
                    result.throttle_out    = (cur_state == MODE_FWD) ? item.throttle_in
                                                                     : rev_thr;
                end
            end
            default:
            begin
                // latched fault: only the brake light follows its input
                result.stop_lamp = item.brake_pedal;
                ev = EV_FAULT;
            end
        endcase

        // apply the configured fault response while driving
        if (drv_fault)
        begin
            case (rsp)
                RSP_CUT:     ev = EV_OK;
                RSP_NEUTRAL: ev = EV_STOP;
                RSP_SDC:
                begin
                    result.shutdown_open = 1'b1;
                    ev = EV_STOP;
                end
                default:
                begin
                    result.shutdown_open = 1'b1;
                    ev = EV_FAULT;
                end
            endcase
        end

        nxt_state              = next_state(cur_state, ev);
        result.drive_state_out = nxt_state;
    end

endmodule

// ===== rtl/drive_mode_safety_fsm.sv =====
// Top level of the drive mode safety state machine: input register, drive
// state register, tick logic and result register.
// Depends on dmsf_pkg, dmsf_cfg and dmsf_core.
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data      | one control tick of inputs
//  out     | out_valid, out_ready, out_data   | new state and drive outputs
//  cfg     | cfg_we, cfg_index, cfg_data      | one register write, no wait
//
// One tick per clock cycle sustained while results are taken; an accepted input
// beat passes through the input register, then the result register, to its result beat.
// The drive state register updates when a tick moves into the result register.
// Reset puts the state in entry and loads the register defaults.
// A stalled result holds the result register, and the input register fills
// behind it before in_ready drops.
`timescale 1ns / 1ps

module drive_mode_safety_fsm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dmsf_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dmsf_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [dmsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmsf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dmsf_pkg::*;

    cfg_t         cfg;
    in_item_t     in_reg;
    logic         in_vld_reg;
    out_item_t    out_reg;
    logic         out_vld_reg;
    drive_state_t state_reg;
    drive_state_t state_next;
    out_item_t    result;
    logic         advance;

    dmsf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dmsf_core u_core (
        .cur_state (state_reg),
        .item      (in_reg),
        .cfg       (cfg),
        .nxt_state (state_next),
        .result    (result)
    );

    // move a tick forward when the result slot is free or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // input and result valid flags and drive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= MODE_INIT;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
        if (advance)
            out_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/dmsf_checker.sv =====
// Port-level checker for the drive mode safety state machine, bound to the
// top level. Depends on dmsf_pkg.
`timescale 1ns / 1ps

module dmsf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input dmsf_pkg::out_item_t out_data
);
    import dmsf_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // throttle is zero whenever it is disabled
    a_thr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.throttle_enable |-> out_data.throttle_out == '0)
        else $error("throttle nonzero while disabled");

    // throttle only reaches the inverter in a driving state
    a_thr_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.throttle_enable |->
            out_data.drive_state_out == MODE_FWD ||
            out_data.drive_state_out == MODE_REV)
        else $error("throttle enabled outside forward or reverse");

    // entering or staying in fault keeps the shutdown circuit open, no throttle
    a_fault_safe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.drive_state_out == MODE_LATCHED |->
            out_data.shutdown_open && !out_data.throttle_enable)
        else $error("fault state with shutdown circuit closed or throttle on");

endmodule

bind drive_mode_safety_fsm dmsf_checker u_dmsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/sv/dmsf_tb_pkg.sv =====
// Scoreboard for the drive mode safety state machine testbench.
// Predicts the result beat of every accepted control tick and checks the block's beats.
// Depends on dmsf_pkg.
`timescale 1ns / 1ps

package dmsf_tb_pkg;

    import dmsf_pkg::*;

    class drive_outputs_scoreboard;

        drive_state_t       drive_mode;
        fault_rsp_t         apps_rsp;
        fault_rsp_t         plaus_rsp;
        fault_rsp_t         range_rsp;
        fault_rsp_t         timeout_rsp;
        fault_rsp_t         ts_lost_rsp;
        logic               rev_enable;
        logic [SCALE_W-1:0] rev_scale;
        out_item_t          expected_outputs[$];
        int unsigned        mismatches;

        // state and registers as they come out of reset
        function new();
            drive_mode  = MODE_INIT;
            apps_rsp    = RSP_CUT;
            plaus_rsp   = RSP_NEUTRAL;
            range_rsp   = RSP_NEUTRAL;
            timeout_rsp = RSP_NEUTRAL;
            ts_lost_rsp = RSP_NEUTRAL;
            rev_enable  = 1'b0;
            rev_scale   = SCALE_W'(128);
            mismatches  = 0;
        endfunction

        // mirror of one register write, unused bits dropped
        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_APPS_RSP:    apps_rsp    = fault_rsp_t'(val[1:0]);
                REG_PLAUS_RSP:   plaus_rsp   = fault_rsp_t'(val[1:0]);
                REG_RANGE_RSP:   range_rsp   = fault_rsp_t'(val[1:0]);
                REG_TIMEOUT_RSP: timeout_rsp = fault_rsp_t'(val[1:0]);
                REG_TS_LOST_RSP: ts_lost_rsp = fault_rsp_t'(val[1:0]);
                REG_REV_ENABLE:  rev_enable  = val[0];
                REG_REV_SCALE:   rev_scale   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        // next state and drive outputs for one accepted tick
        function void predict_tick(in_item_t t);
            out_item_t           r;
            drive_state_t        nxt;
            fault_rsp_t          rsp;
            logic                hit;
            logic                released;
            logic [PROD_W-1:0]   scaled;

            r               = '0;
            r.shutdown_open = 1'b1;
            nxt             = drive_mode;
            rsp             = RSP_CUT;
            hit             = 1'b0;

            case (drive_mode)
                MODE_INIT:
                begin
                    nxt = MODE_IDLE;
                end
                MODE_IDLE:
                begin
                    r.stop_lamp     = t.brake_pedal;
                    r.shutdown_open = 1'b0;
                    if (t.forward_switch && t.tractive_active)
                        nxt = MODE_NEUTRAL;
                end
                MODE_NEUTRAL:
                begin
                    r.inverter_relay = 1'b1;
                    r.stop_lamp      = t.brake_pedal;
                    r.shutdown_open  = 1'b0;
                    // reverse request wins over forward when reverse is allowed
                    if (rev_enable && !t.forward_switch && !t.reverse_switch)
                        nxt = MODE_IDLE;
                    else if (!rev_enable && !t.forward_switch)
                        nxt = MODE_IDLE;
                    else if (rev_enable && t.reverse_switch && t.ready_button
                             && t.brake_pedal)
                    begin
                        r.beep_request  = 1'b1;
                        r.motor_reverse = 1'b1;
                        nxt             = MODE_REV;
                    end
                    else if (t.forward_switch && t.ready_button && t.brake_pedal)
                    begin
                        r.beep_request = 1'b1;
                        nxt            = MODE_FWD;
                    end
                end
                MODE_FWD, MODE_REV:
                begin
                    r.inverter_relay = 1'b1;
                    r.stop_lamp      = t.brake_pedal;
                    r.shutdown_open  = 1'b0;
                    r.motor_reverse  = (drive_mode == MODE_REV);
                    released = (drive_mode == MODE_FWD) ? !t.forward_switch
                                                        : !t.reverse_switch;
                    if (released)
                    begin
                        nxt = MODE_NEUTRAL;
                    end
                    else
                    begin
                        // first active fault in priority order picks the response
                        hit = 1'b1;
                        if (!t.tractive_active)       rsp = ts_lost_rsp;
                        else if (t.fault_apps)         rsp = apps_rsp;
                        else if (t.fault_plausibility) rsp = plaus_rsp;
                        else if (t.fault_range)        rsp = range_rsp;
                        else if (t.fault_timeout)      rsp = timeout_rsp;
                        else                           hit = 1'b0;

                        if (hit)
                        begin
                            case (rsp)
                                RSP_NEUTRAL: nxt = MODE_NEUTRAL;
                                RSP_SDC:
                                begin
                                    r.shutdown_open = 1'b1;
                                    nxt             = MODE_NEUTRAL;
                                end
                                RSP_LATCH:
                                begin
                                    r.shutdown_open = 1'b1;
                                    nxt             = MODE_LATCHED;
                                end
                                default: ;  // cut: hold state with throttle off
                            endcase
                        end
                        else if (drive_mode == MODE_FWD)
                        begin
                            r.throttle_enable = 1'b1;
                            r.throttle_out    = t.throttle_in;
                        end
                        else
                        begin
                            // reverse throttle in units of 1/256, saturated
                            scaled = t.throttle_in * rev_scale;
                            scaled = scaled >> SCALE_FRAC;
                            if (scaled > THR_MAX)
                                scaled = THR_MAX;
                            r.throttle_enable = 1'b1;
                            r.throttle_out    = scaled[THROTTLE_W-1:0];
                        end
                    end
                end
                default:
                begin
                    // latched fault: only the brake light lives
                    r.stop_lamp = t.brake_pedal;
                    nxt         = MODE_LATCHED;
                end
            endcase

            r.drive_state_out = nxt;
            drive_mode        = nxt;
            expected_outputs.push_back(r);
        endfunction

        function void check_field(string fname, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", fname, want, got);
            end
        endfunction

        // compare one result beat against the oldest prediction
        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_outputs.size() == 0)
            begin
                mismatches++;
                $error("result beat with no tick pending: %h", got);
                return;
            end
            want = expected_outputs.pop_front();
            check_field("drive_state_out", 16'(want.drive_state_out),
                        16'(got.drive_state_out));
            check_field("throttle_enable", 16'(want.throttle_enable),
                        16'(got.throttle_enable));
            check_field("throttle_out", 16'(want.throttle_out), 16'(got.throttle_out));
            check_field("inverter_relay", 16'(want.inverter_relay),
                        16'(got.inverter_relay));
            check_field("stop_lamp", 16'(want.stop_lamp), 16'(got.stop_lamp));
            check_field("shutdown_open", 16'(want.shutdown_open), 16'(got.shutdown_open));
            check_field("beep_request", 16'(want.beep_request), 16'(got.beep_request));
            check_field("motor_reverse", 16'(want.motor_reverse), 16'(got.motor_reverse));
        endfunction

    endclass

endpackage

// ===== tb/sv/drive_mode_safety_fsm_test.sv =====
// Top of the drive mode safety state machine testbench: directed ticks, then
// random drive sessions over several register settings, with random idling.
// Depends on dmsf_pkg, dmsf_tb_pkg and the drive_mode_safety_fsm RTL.
`timescale 1ns / 1ps

module drive_mode_safety_fsm_test;

    import dmsf_pkg::*;
    import dmsf_tb_pkg::*;

    // fault flag groups, ordered {apps, plausibility, range, timeout}
    localparam logic [3:0] FLT_NONE    = 4'b0000;
    localparam logic [3:0] FLT_APPS    = 4'b1000;
    localparam logic [3:0] FLT_PLAUS   = 4'b0100;
    localparam logic [3:0] FLT_RANGE   = 4'b0010;
    localparam logic [3:0] FLT_TIMEOUT = 4'b0001;

    // index past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam int ITEMS_TARGET  = 1150;
    localparam int LATCH_ITEMS   = 120;
    localparam int RANDOM_PHASES = 8;

    typedef enum {TK_NOISE, TK_ARM, TK_START, TK_DRIVE} tick_kind_t;
    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_style_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    drive_outputs_scoreboard scoreboard = new();

    int        burst_left = 0;
    int        tick_count = 0;
    int        rx_left    = 0;
    rx_style_t rx_style   = RX_OPEN;

    drive_mode_safety_fsm DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver stall pattern, style redrawn each time its random run counter expires
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_left  <= $urandom_range(16, 96);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_OPEN:   out_ready <= 1'b1;
            RX_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= (rx_left[1:0] != 2'd0);
        endcase
    end

    // beat monitor: results checked before the tick of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                scoreboard.check_result(out_data);
            if (in_valid && in_ready)
                scoreboard.predict_tick(in_data);
        end
    end

    function automatic in_item_t tick_of(int brake, int fwd, int rvs, int rdy,
                                         int ts, logic [3:0] flt,
                                         logic [THROTTLE_W-1:0] thr);
        in_item_t t;
        t.brake_pedal     = 1'(brake);
        t.forward_switch  = 1'(fwd);
        t.reverse_switch  = 1'(rvs);
        t.ready_button    = 1'(rdy);
        t.tractive_active = 1'(ts);
        {t.fault_apps, t.fault_plausibility, t.fault_range, t.fault_timeout} = flt;
        t.throttle_in     = thr;
        return t;
    endfunction

    function automatic logic [THROTTLE_W-1:0] pick_throttle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return THR_MAX;
            2:       return THROTTLE_W'(1);
            3:       return {1'b1, {(THROTTLE_W-1){1'b0}}};
            default: return THROTTLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(128);
            3:       return CFG_DATA_W'(255);
            4:       return CFG_DATA_W'(256);
            5:       return CFG_DATA_W'(257);
            6:       return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic fault_rsp_t pick_soft_rsp();
        return fault_rsp_t'($urandom_range(RSP_CUT, RSP_SDC));
    endfunction

    // one tick of a drive session; noise is fully random
    function automatic in_item_t make_tick(tick_kind_t kind, logic to_reverse);
        logic [$bits(in_item_t)-1:0] raw;
        in_item_t                    t;
        raw           = $bits(in_item_t)'($urandom);
        t             = raw;
        t.throttle_in = pick_throttle();
        if (kind != TK_NOISE)
        begin
            t.tractive_active = 1'b1;
            {t.fault_apps, t.fault_plausibility, t.fault_range, t.fault_timeout} = FLT_NONE;
            if (!to_reverse)
                t.forward_switch = 1'b1;
            t.reverse_switch = to_reverse ? 1'b1 : ($urandom_range(0, 9) == 0);
        end
        case (kind)
            TK_ARM:
            begin
                t.forward_switch = 1'b1;
                t.ready_button   = 1'b0;
            end
            TK_START:
            begin
                t.ready_button = 1'b1;
                t.brake_pedal  = 1'b1;
            end
            TK_DRIVE:
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0: t.tractive_active    = 1'b0;
                        1: t.fault_apps         = 1'b1;
                        2: t.fault_plausibility = 1'b1;
                        3: t.fault_range        = 1'b1;
                        4: t.fault_timeout      = 1'b1;
                        default:
                            {t.tractive_active, t.fault_apps, t.fault_plausibility,
                             t.fault_range, t.fault_timeout} = 5'($urandom);
                    endcase
                end
                // occasional release of the selected direction switch
                if ($urandom_range(0, 29) == 0)
                begin
                    if (to_reverse)
                        t.reverse_switch = 1'b0;
                    else
                        t.forward_switch = 1'b0;
                end
            end
            default: ;
        endcase
        return t;
    endfunction

    // send one tick beat, with bursts and random gaps in between
    task automatic push_tick(input in_item_t t);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                8:          gap = $urandom_range(5, 12);
                default:    gap = $urandom_range(1, 4);
            endcase
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        in_data  <= t;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        tick_count++;
    endtask

    // wait until every predicted result has been seen, then let the pipe empty
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        scoreboard.load_reg(idx, val);
    endtask

    // full register setting, written while the block is idle; junk in unused bits
    task automatic program_regs(input fault_rsp_t apps, input fault_rsp_t plaus,
                                input fault_rsp_t range_f, input fault_rsp_t tmo,
                                input fault_rsp_t ts_lost, input logic rev_en,
                                input logic [CFG_DATA_W-1:0] scale);
        settle();
        write_reg(REG_APPS_RSP,    {(CFG_DATA_W-2)'($urandom), apps});
        write_reg(REG_PLAUS_RSP,   {(CFG_DATA_W-2)'($urandom), plaus});
        write_reg(REG_RANGE_RSP,   {(CFG_DATA_W-2)'($urandom), range_f});
        write_reg(REG_TIMEOUT_RSP, {(CFG_DATA_W-2)'($urandom), tmo});
        write_reg(REG_TS_LOST_RSP, {(CFG_DATA_W-2)'($urandom), ts_lost});
        write_reg(REG_REV_ENABLE,  {(CFG_DATA_W-1)'($urandom), rev_en});
        write_reg(REG_REV_SCALE,   scale);
        write_reg(REG_UNMAPPED,    CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // arm, ready-to-drive, a run of driving ticks, a little noise
    task automatic run_session(input logic to_reverse);
        int drive_len;
        drive_len = $urandom_range(4, 30);
        push_tick(make_tick(TK_ARM, to_reverse));
        push_tick(make_tick(TK_ARM, to_reverse));
        push_tick(make_tick(TK_START, to_reverse));
        repeat (drive_len) push_tick(make_tick(TK_DRIVE, to_reverse));
        repeat ($urandom_range(0, 2)) push_tick(make_tick(TK_NOISE, to_reverse));
    endtask

    task automatic run_items(input int count, input int rev_pct);
        int stop_at;
        stop_at = tick_count + count;
        while (tick_count < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) push_tick(make_tick(TK_NOISE, 1'b0));
            else
                run_session($urandom_range(0, 99) < rev_pct);
        end
    endtask

    initial
    begin
        logic                  rev_en;
        logic [CFG_DATA_W-1:0] scale;
        in_item_t              t;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, forward path and fault priorities
        push_tick(tick_of(1, 1, 1, 1, 1, 4'b1111, THR_MAX));     // entry ignores inputs
        push_tick(tick_of(1, 0, 0, 0, 1, FLT_NONE, 12'd100));   // standby holds
        push_tick(tick_of(0, 1, 0, 0, 1, FLT_NONE, 12'd0));     // to neutral
        push_tick(tick_of(1, 0, 1, 1, 1, FLT_NONE, 12'd0));     // forward off, back to standby
        push_tick(tick_of(0, 1, 0, 0, 1, FLT_NONE, 12'd0));
        push_tick(tick_of(0, 1, 0, 1, 1, FLT_NONE, 12'd0));     // no brake, no start
        push_tick(tick_of(1, 1, 0, 1, 1, FLT_NONE, 12'd0));     // ready to drive forward
        push_tick(tick_of(0, 1, 0, 0, 1, FLT_NONE, THR_MAX));
        push_tick(tick_of(1, 1, 0, 0, 1, FLT_NONE, 12'd0));
        push_tick(tick_of(0, 1, 0, 0, 1, FLT_APPS | FLT_RANGE, 12'd800)); // cut hides range
        push_tick(tick_of(0, 1, 0, 0, 1, FLT_PLAUS, 12'd800));
        push_tick(tick_of(1, 1, 0, 1, 1, FLT_NONE, 12'd0));
        push_tick(tick_of(0, 1, 0, 0, 1, FLT_TIMEOUT, 12'd5));
        push_tick(tick_of(1, 1, 0, 1, 1, FLT_NONE, 12'd0));
        push_tick(tick_of(0, 1, 0, 0, 0, FLT_APPS, 12'd5));     // tractive loss first
        push_tick(tick_of(1, 1, 0, 1, 1, FLT_NONE, 12'd0));
        push_tick(tick_of(0, 0, 0, 0, 1, FLT_NONE, 12'd9));     // forward released

        // directed: reverse path with saturating scale
        program_regs(RSP_CUT, RSP_NEUTRAL, RSP_SDC, RSP_NEUTRAL, RSP_SDC, 1'b1, '1);
        push_tick(tick_of(0, 0, 0, 0, 1, FLT_NONE, 12'd0));     // both off, to standby
        push_tick(tick_of(0, 1, 0, 0, 1, FLT_NONE, 12'd0));
        push_tick(tick_of(1, 1, 1, 1, 1, FLT_NONE, 12'd0));     // reverse wins
        push_tick(tick_of(0, 0, 1, 0, 1, FLT_NONE, THR_MAX));
        push_tick(tick_of(0, 1, 1, 0, 1, FLT_RANGE, 12'd7));    // shutdown open, neutral
        push_tick(tick_of(1, 0, 1, 1, 1, FLT_NONE, 12'd0));

        // directed: reverse disabled while already in reverse, zero scale
        program_regs(RSP_CUT, RSP_NEUTRAL, RSP_SDC, RSP_NEUTRAL, RSP_SDC, 1'b0, '0);
        push_tick(tick_of(0, 0, 1, 0, 1, FLT_NONE, THR_MAX));
        push_tick(tick_of(0, 0, 0, 0, 1, FLT_NONE, 12'd0));
        push_tick(tick_of(1, 0, 1, 1, 1, FLT_NONE, 12'd0));

        // random phases, no latching responses yet
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                rev_en = 1'b1;
                scale  = CFG_DATA_W'(256);
                program_regs(RSP_CUT, RSP_CUT, RSP_CUT, RSP_CUT, RSP_CUT, rev_en, scale);
            end
            else if (phase == 1)
            begin
                rev_en = 1'b1;
                scale  = '1;
                program_regs(RSP_SDC, RSP_SDC, RSP_SDC, RSP_SDC, RSP_SDC, rev_en, scale);
            end
            else
            begin
                rev_en = 1'($urandom_range(0, 1));
                scale  = pick_scale();
                program_regs(pick_soft_rsp(), pick_soft_rsp(), pick_soft_rsp(),
                             pick_soft_rsp(), pick_soft_rsp(), rev_en, scale);
            end
            run_items((ITEMS_TARGET - LATCH_ITEMS) / RANDOM_PHASES, rev_en ? 50 : 15);
        end

        // last phase: any fault latches, then only reset could leave
        rev_en = 1'($urandom_range(0, 1));
        program_regs(RSP_LATCH, RSP_LATCH, RSP_LATCH, RSP_LATCH, RSP_LATCH, rev_en,
                     CFG_DATA_W'(256));
        run_items(LATCH_ITEMS / 2, rev_en ? 50 : 15);
        t = make_tick(TK_DRIVE, 1'b0);
        t.fault_range = 1'b1;
        push_tick(t);
        run_items(LATCH_ITEMS / 2, 20);

        settle();
        repeat (4) @(posedge clk);
        if (scoreboard.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dmsf_pkg.sv
rtl/dmsf_cfg.sv
rtl/dmsf_core.sv
rtl/drive_mode_safety_fsm.sv
rtl/dmsf_checker.sv
tb/sv/dmsf_tb_pkg.sv
tb/sv/drive_mode_safety_fsm_test.sv
